// File: src/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 16;
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		CMD_PUSH  = 4'd0,
		CMD_ADD   = 4'd1,
		CMD_SUB   = 4'd2,
		CMD_MUL   = 4'd3,
		CMD_DIV   = 4'd4,
		CMD_NEG   = 4'd5,
		CMD_DUP   = 4'd6,
		CMD_SWAP  = 4'd7,
		CMD_PRINT = 4'd8,
		CMD_CLEAR = 4'd9,
		CMD_PALL  = 4'd10
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_PRINT = 3'd1,
		ST_FEW   = 3'd2,
		ST_FULL  = 3'd3,
		ST_DIV0  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_MUL = 3'd2,
		ALU_DIV = 3'd3,
		ALU_NEG = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] push_value;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] result_value;
		logic               last;
	} out_beat_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} alu_rsp_t;

endpackage

// File: src/rsc_alu.sv
`timescale 1ns / 1ps

module rsc_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  rsc_pkg::alu_req_t req,
	input  logic [31:0]      opa,
	input  logic [31:0]      opb,
	output rsc_pkg::alu_rsp_t rsp
);
	import rsc_pkg::*;

	typedef enum logic [3:0] {
		AS_IDLE = 4'b0001,
		AS_MUL  = 4'b0010,
		AS_DIV  = 4'b0100,
		AS_FIN  = 4'b1000
	} alu_state_t;

	alu_state_t  state_q;
	logic        done_q;
	logic [31:0] res_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] dvsr_q;
	logic        neg_q;
	logic [5:0]  step_q;

	logic [31:0] mag_a, mag_b;
	logic [32:0] sum;
	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic        ge;

	// Apply sign to a magnitude and clamp to the Q16.16 range
	function automatic logic [31:0] smag(input logic [47:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m > 48'h0000_8000_0000) r = 32'h8000_0000;
			else r = 32'(-m[31:0]);
		end else begin
			if (m > 48'h0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = m[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sat33(input logic [32:0] s);
		logic [31:0] r;
		if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else r = s[31:0];
		return r;
	endfunction

	assign mag_a = opa[31] ? 32'(-opa) : opa;
	assign mag_b = opb[31] ? 32'(-opb) : opb;
	assign sum   = (req.op == ALU_SUB) ? ({opa[31], opa} - {opb[31], opb})
	                                   : ({opa[31], opa} + {opb[31], opb});

	// One restoring division step
	assign rem_sh = {rem_q, quo_q[47]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvsr_q};
	assign ge     = ~diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				AS_IDLE: begin
					if (req.start) begin
						case (req.op)
							ALU_MUL: state_q <= AS_MUL;
							ALU_DIV: begin
								state_q <= AS_DIV;
								step_q  <= '0;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				AS_MUL: begin
					state_q <= AS_IDLE;
					done_q  <= 1'b1;
				end
				AS_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd47) state_q <= AS_FIN;
				end
				AS_FIN: begin
					state_q <= AS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= AS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AS_IDLE: begin
				if (req.start) begin
					neg_q  <= opa[31] ^ opb[31];
					prod_q <= mag_a * mag_b;
					rem_q  <= '0;
					quo_q  <= {mag_a, 16'h0000};
					dvsr_q <= mag_b;
					case (req.op)
						// Negate works on the top entry, which arrives on opb
						ALU_NEG: res_q <= (opb == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'(-opb);
						default: res_q <= sat33(sum);
					endcase
				end
			end
			AS_MUL:  res_q <= smag(prod_q[63:16], neg_q);
			AS_DIV: begin
				rem_q <= ge ? diff[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[46:0], ge};
			end
			AS_FIN:  res_q <= smag(quo_q, neg_q);
			default: res_q <= res_q;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// File: src/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps

// RPN stack calculator on signed Q16.16 values.
// Input channel (in_valid/in_ready/in_data): one beat per command: push,
// add, sub, mul, div, negate, dup, swap, print, clear or print all. The
// second entry is the left operand, the top entry the right one.
// Output channel (out_valid/out_ready/out_data): one beat per command with
// status and new top of stack, or one beat per entry for print all, top
// first; last marks the final beat. Codes 11 to 15 give no beat.
// Timing: one command is in flight at a time; in_ready is high only while
// the sequencer idles. Divide runs 48 restoring steps in the shared
// arithmetic unit. Print all reads and sends one entry at a time, a read
// state and then an output state per entry, holding while output stalls.
// The output register decouples the sides: a new command is taken while
// the previous beat still waits; a stalled receiver holds the sequencer
// only when it must hand over its next beat.
// Reset clears the entry count and control state; stack entries hold
// garbage until written, and their values are never used before that.

module rpn_stack_calculator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rsc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rsc_pkg::out_beat_t out_data
);
	import rsc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_ALU    = 7'b0000100,
		S_SWAP   = 7'b0001000,
		S_RESP   = 7'b0010000,
		S_PA_RD  = 7'b0100000,
		S_PA_OUT = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [3:0]       cmd_q;
	logic [31:0]      pv_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] pa_idx_q;
	logic [2:0]       rsp_status_q;
	logic [31:0]      rsp_value_q;
	logic             out_valid_q;
	out_beat_t        out_q;

	// Stack memory with registered reads
	logic [31:0]      stack_mem_q [STACK_DEPTH];
	logic [31:0]      rd_top_q;
	logic [31:0]      rd_sec_q;

	logic [CNT_W-1:0] cnt_m1, cnt_m2;
	logic [IDX_W-1:0] top_idx, sec_idx, push_idx, rd_addr;
	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic             empty, full, few2;
	logic [31:0]      top_or_zero;
	logic             out_free;
	logic             out_load;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	assign cnt_m1      = count_q - CNT_W'(1);
	assign cnt_m2      = count_q - CNT_W'(2);
	assign top_idx     = cnt_m1[IDX_W-1:0];
	assign sec_idx     = cnt_m2[IDX_W-1:0];
	assign push_idx    = count_q[IDX_W-1:0];
	assign empty       = (count_q == '0);
	assign full        = (count_q >= CNT_W'(STACK_DEPTH));
	assign few2        = (count_q < CNT_W'(2));
	assign top_or_zero = empty ? 32'h0 : rd_top_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = ~out_valid_q | out_ready;
	assign out_load = ((state_q == S_RESP) || (state_q == S_PA_OUT)) && out_free;

	// Read on command entry, and once per entry while walking print all
	assign rd_en   = (in_valid && in_ready) || (state_q == S_PA_RD);
	assign rd_addr = (state_q == S_PA_RD) ? pa_idx_q : top_idx;

	rsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (rd_sec_q),
		.opb    (rd_top_q),
		.rsp    (alu_rsp)
	);

	// Operation start for the shared arithmetic unit
	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = ALU_ADD;
		if (state_q == S_EXEC) begin
			case (cmd_q)
				CMD_ADD: alu_req.start = ~few2;
				CMD_SUB: begin
					alu_req.start = ~few2;
					alu_req.op    = ALU_SUB;
				end
				CMD_MUL: begin
					alu_req.start = ~few2;
					alu_req.op    = ALU_MUL;
				end
				CMD_DIV: begin
					alu_req.start = ~few2 && (rd_top_q != 32'h0);
					alu_req.op    = ALU_DIV;
				end
				CMD_NEG: begin
					alu_req.start = ~empty;
					alu_req.op    = ALU_NEG;
				end
				default: alu_req.start = 1'b0;
			endcase
		end
	end

	// Stack write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = push_idx;
		wr_data = pv_q;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_PUSH: wr_en = ~full;
					CMD_DUP: begin
						wr_en   = ~full && ~empty;
						wr_data = rd_top_q;
					end
					CMD_SWAP: begin
						wr_en   = ~few2;
						wr_addr = top_idx;
						wr_data = rd_sec_q;
					end
					default: wr_en = 1'b0;
				endcase
			end
			S_ALU: begin
				wr_en   = alu_rsp.done;
				wr_addr = (cmd_q == CMD_NEG) ? top_idx : sec_idx;
				wr_data = alu_rsp.res;
			end
			S_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = sec_idx;
				wr_data = rd_top_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) stack_mem_q[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_top_q <= stack_mem_q[rd_addr];
			rd_sec_q <= stack_mem_q[sec_idx];
		end
	end

	// Command latch and response payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_data.command;
			pv_q  <= in_data.push_value;
		end
		if (out_load) begin
			if (state_q == S_PA_OUT) begin
				out_q.status       <= ST_PRINT;
				out_q.result_value <= rd_top_q;
				out_q.last         <= (pa_idx_q == '0);
			end else begin
				out_q.status       <= rsp_status_q;
				out_q.result_value <= rsp_value_q;
				out_q.last         <= 1'b1;
			end
		end
		case (state_q)
			S_EXEC: begin
				rsp_status_q <= ST_FEW;
				rsp_value_q  <= top_or_zero;
				pa_idx_q     <= top_idx;
				case (cmd_q)
					CMD_PUSH: begin
						if (full) begin
							rsp_status_q <= ST_FULL;
						end else begin
							rsp_status_q <= ST_OK;
							rsp_value_q  <= pv_q;
						end
					end
					CMD_DUP: begin
						if (!empty) rsp_status_q <= full ? ST_FULL : ST_OK;
					end
					CMD_DIV: begin
						if (!few2 && rd_top_q == 32'h0) rsp_status_q <= ST_DIV0;
					end
					CMD_SWAP: begin
						rsp_status_q <= few2 ? ST_FEW : ST_OK;
						if (!few2) rsp_value_q <= rd_sec_q;
					end
					CMD_PRINT: begin
						if (!empty) rsp_status_q <= ST_PRINT;
					end
					CMD_CLEAR: begin
						rsp_status_q <= ST_OK;
						rsp_value_q  <= 32'h0;
					end
					default: rsp_status_q <= ST_FEW;
				endcase
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					rsp_status_q <= ST_OK;
					rsp_value_q  <= alu_rsp.res;
				end
			end
			S_PA_OUT: begin
				if (out_free) pa_idx_q <= pa_idx_q - IDX_W'(1);
			end
			default: rsp_status_q <= rsp_status_q;
		endcase
	end

	// Sequencer, entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
					case (cmd_q)
						CMD_PUSH: if (!full) count_q <= count_q + CNT_W'(1);
						CMD_DUP:  if (!full && !empty) count_q <= count_q + CNT_W'(1);
						CMD_ADD, CMD_SUB, CMD_MUL: if (!few2) state_q <= S_ALU;
						CMD_DIV:  if (!few2 && rd_top_q != 32'h0) state_q <= S_ALU;
						CMD_NEG:  if (!empty) state_q <= S_ALU;
						CMD_SWAP: if (!few2) state_q <= S_SWAP;
						CMD_PRINT: state_q <= S_RESP;
						CMD_CLEAR: count_q <= '0;
						CMD_PALL: if (!empty) state_q <= S_PA_RD;
						default:  state_q <= S_IDLE;
					endcase
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						state_q <= S_RESP;
						if (cmd_q != CMD_NEG) count_q <= cnt_m1;
					end
				end
				S_SWAP:  state_q <= S_RESP;
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_PA_RD: state_q <= S_PA_OUT;
				S_PA_OUT: begin
					// Advance to the next lower entry, drop out after the bottom one
					if (out_free) state_q <= (pa_idx_q == '0) ? S_IDLE : S_PA_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: tb/rsc_result_checker.sv
`timescale 1ns / 1ps

// Watch both channels, keep a shadow stack and compare every output beat
// against the oldest predicted beat.
module rsc_result_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  rsc_pkg::in_beat_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  rsc_pkg::out_beat_t out_data,
	output int                mismatches,
	output int                pending_results
);
	import rsc_pkg::*;

	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;

	logic [31:0] shadow_stack [STACK_DEPTH];
	int          shadow_depth;
	out_beat_t   awaited_results [$];

	function automatic logic [31:0] clamp_q(longint s);
		if (s > Q_HI) return 32'h7FFF_FFFF;
		if (s < Q_LO) return 32'h8000_0000;
		return 32'(s);
	endfunction

	function automatic logic [63:0] magnitude(logic [31:0] v);
		longint s;
		s = longint'($signed(v));
		return (s < 0) ? 64'(-s) : 64'(s);
	endfunction

	// Saturate an unsigned magnitude back into Q16.16 with the given sign.
	function automatic logic [31:0] apply_sign(logic [63:0] m, bit neg);
		if (neg) return (m > 64'd2147483648) ? 32'h8000_0000 : 32'(-m);
		return (m > 64'd2147483647) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic predict_results(in_beat_t beat);
		logic [31:0] left;
		logic [31:0] right;
		logic [31:0] res;
		status_t     st;
		int          n;
		bit          neg;
		n  = shadow_depth;
		st = ST_OK;
		res = '0;
		case (beat.command)
			CMD_PUSH: begin
				if (n >= STACK_DEPTH) st = ST_FULL;
				else begin
					shadow_stack[n] = beat.push_value;
					shadow_depth    = n + 1;
				end
			end
			CMD_DUP: begin
				if (n == 0) st = ST_FEW;
				else if (n >= STACK_DEPTH) st = ST_FULL;
				else begin
					shadow_stack[n] = shadow_stack[n - 1];
					shadow_depth    = n + 1;
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
				if (n < 2) st = ST_FEW;
				else begin
					left  = shadow_stack[n - 2];
					right = shadow_stack[n - 1];
					neg   = left[31] ^ right[31];
					case (beat.command)
						CMD_ADD: res = clamp_q(longint'($signed(left)) + longint'($signed(right)));
						CMD_SUB: res = clamp_q(longint'($signed(left)) - longint'($signed(right)));
						CMD_MUL: res = apply_sign((magnitude(left) * magnitude(right)) >> 16, neg);
						default: begin
							if (right == '0) st = ST_DIV0;
							else res = apply_sign((magnitude(left) << 16) / magnitude(right), neg);
						end
					endcase
					if (st == ST_OK) begin
						shadow_stack[n - 2] = res;
						shadow_depth        = n - 1;
					end
				end
			end
			CMD_NEG: begin
				if (n == 0) st = ST_FEW;
				else shadow_stack[n - 1] = clamp_q(-longint'($signed(shadow_stack[n - 1])));
			end
			CMD_SWAP: begin
				if (n < 2) st = ST_FEW;
				else begin
					res                 = shadow_stack[n - 1];
					shadow_stack[n - 1] = shadow_stack[n - 2];
					shadow_stack[n - 2] = res;
				end
			end
			CMD_PRINT: begin
				if (n == 0) st = ST_FEW;
				else begin
					awaited_results.push_back(out_beat_t'{status: ST_PRINT,
						result_value: shadow_stack[n - 1], last: 1'b1});
					return;
				end
			end
			CMD_CLEAR: shadow_depth = 0;
			CMD_PALL: begin
				if (n == 0) st = ST_FEW;
				else begin
					// Walk from top to bottom, last on the bottom entry.
					for (int i = n - 1; i >= 0; i--)
						awaited_results.push_back(out_beat_t'{status: ST_PRINT,
							result_value: shadow_stack[i], last: (i == 0)});
					return;
				end
			end
			default: return;
		endcase
		awaited_results.push_back(out_beat_t'{status: st,
			result_value: (shadow_depth == 0) ? 32'h0 : shadow_stack[shadow_depth - 1],
			last: 1'b1});
	endtask

	task automatic check_result(out_beat_t got);
		out_beat_t want;
		if (awaited_results.size() == 0) begin
			flag_mismatch("beat with nothing awaited", got.result_value, '0);
			return;
		end
		want = awaited_results.pop_front();
		if (got.status != want.status)
			flag_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.result_value != want.result_value)
			flag_mismatch("result_value", got.result_value, want.result_value);
		if (got.last != want.last)
			flag_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_depth = 0;
			mismatches   = 0;
			awaited_results.delete();
			pending_results <= 0;
		end else begin
			if (out_valid && out_ready) check_result(out_data);
			if (in_valid && in_ready) predict_results(in_data);
			pending_results <= awaited_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the RPN stack calculator. The checker beside the
// block owns prediction and comparison; this module only drives commands,
// toggles the receiver's ready and decides pass or fail.
module tb_top;
	import rsc_pkg::*;

	// Unused command codes: the block must swallow them without a beat.
	localparam logic [3:0]  CMD_SPARE_LO = 4'd11;
	localparam logic [3:0]  CMD_SPARE_HI = 4'd15;

	localparam logic [31:0] Q_MAX_VAL = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN_VAL = 32'h8000_0000;
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] Q_HALF    = 32'h0000_8000;

	localparam int RANDOM_ITEMS = 280;
	// Divide is the slowest command; allow well beyond it.
	localparam int DRAIN_CYCLES = 200;
	// Worst case per command: a divide plus sixteen print beats, each stalled.
	localparam int unsigned CYCLE_LIMIT = 600_000;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	int          fail_count;
	int          pending_results;
	bit          no_idle = 1'b0;
	int unsigned cycle_count = 0;

	rpn_stack_calculator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	rsc_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatches     (fail_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the receiver about a third of the time, except in the steady window.
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 34);
	end

	// Watchdog: a hung handshake or a lost beat ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rpn_stack_calculator_top verification failed");
			$finish;
		end
	end

	// Mix of extremes, zeros (for divide by zero), small values and raw bits.
	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return Q_MAX_VAL;
			2:       return Q_MIN_VAL;
			3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom();
		endcase
	endfunction

	// While filling, pushes and dups dominate so the stack reaches full depth;
	// while draining, arithmetic and prints take over and clears happen.
	function automatic logic [3:0] pick_command(bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) return 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		if (filling) begin
			if (roll < 58) return CMD_PUSH;
			if (roll < 68) return CMD_DUP;
		end else begin
			if (roll < 7) return CMD_CLEAR;
			if (roll < 30) return CMD_PUSH;
		end
		case ($urandom_range(0, 8))
			0:       return CMD_ADD;
			1:       return CMD_SUB;
			2:       return CMD_MUL;
			3:       return CMD_DIV;
			4:       return CMD_NEG;
			5:       return CMD_DUP;
			6:       return CMD_SWAP;
			7:       return CMD_PRINT;
			default: return CMD_PALL;
		endcase
	endfunction

	// Present one command beat and hold it until accepted. Valid stays high
	// into the next call unless that call decides to idle first.
	task automatic send_cmd(logic [3:0] code, logic [31:0] value);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 34) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= in_beat_t'{command: code, push_value: value};
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		int         sent;
		bit         filling;
		logic [3:0] code;

		in_valid <= 1'b0;
		in_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: errors on an empty stack first.
		send_cmd(CMD_PRINT, $urandom());
		send_cmd(CMD_PALL, $urandom());
		send_cmd(CMD_NEG, $urandom());
		send_cmd(CMD_DUP, $urandom());
		send_cmd(CMD_SWAP, $urandom());
		// One operand only, then positive saturation of add and mul.
		send_cmd(CMD_PUSH, Q_MAX_VAL);
		send_cmd(CMD_ADD, $urandom());
		send_cmd(CMD_DUP, $urandom());
		send_cmd(CMD_ADD, $urandom());
		send_cmd(CMD_PUSH, Q_MIN_VAL);
		send_cmd(CMD_NEG, $urandom());
		send_cmd(CMD_MUL, $urandom());
		// Divide by zero leaves the stack alone.
		send_cmd(CMD_PUSH, '0);
		send_cmd(CMD_DIV, $urandom());
		send_cmd(CMD_PUSH, Q_MIN_VAL);
		send_cmd(CMD_SWAP, $urandom());
		send_cmd(CMD_PALL, $urandom());
		send_cmd(CMD_SPARE_LO, $urandom());
		// Zero divided by a fraction, then negative saturation of sub.
		send_cmd(CMD_PUSH, Q_HALF);
		send_cmd(CMD_DIV, $urandom());
		send_cmd(CMD_SUB, $urandom());
		send_cmd(CMD_PUSH, Q_ONE);
		send_cmd(CMD_SUB, $urandom());
		send_cmd(CMD_PRINT, $urandom());
		// Clear twice: the second hits an empty stack.
		send_cmd(CMD_CLEAR, $urandom());
		send_cmd(CMD_CLEAR, $urandom());

		// Random: alternate fill and drain phases; spare codes do not count.
		sent    = 0;
		filling = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			no_idle = (sent >= 120) && (sent < 200);
			if ($urandom_range(0, 29) == 0) filling = !filling;
			code = pick_command(filling);
			send_cmd(code, rand_q16());
			if (code <= CMD_PALL) sent++;
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		// Drain: wait for every predicted beat, then watch for stray ones.
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("rpn_stack_calculator_top verification clean");
		end else begin
			$display("rpn_stack_calculator_top verification failed");
		end
		$finish;
	end

endmodule
